@@ design/tslf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_pkg: shared types, constants and helpers of the scene layer fader
// Holds the scene entry layout, the per-cell control struct, command and
// register codes, and the blend and saturating time helpers.
// ----------------------------------------------------------------------------
package tslf_pkg;

  localparam int MAX_SCENES = 8;
  localparam int STEP_W     = $clog2(MAX_SCENES + 1);

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_EXTEND = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_MANUAL = 3'd5;

  localparam logic [2:0] REG_BG_BRIGHT = 3'd0;
  localparam logic [2:0] REG_BG_MIREK  = 3'd1;
  localparam logic [2:0] REG_BG_X      = 3'd2;
  localparam logic [2:0] REG_BG_Y      = 3'd3;
  localparam logic [2:0] REG_GAIN      = 3'd4;
  localparam logic [2:0] REG_MIN_DIM   = 3'd5;

  localparam logic [16:0] Q16_ONE     = 17'h10000;
  localparam logic [13:0] BRIGHT_MAX  = 14'd10000;
  localparam logic [12:0] PCT_RECIP   = 13'd5243;  // 2^19 / 100, rounded up
  localparam logic [10:0] TR_MANUAL   = 11'd1000;
  localparam logic [10:0] TR_SCENE    = 11'd2000;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [31:0] fade;
    logic [47:0] start_ms;
    logic [47:0] rel_ms;
    logic [31:0] hold;
    logic [13:0] level;
    logic [9:0]  mirek;
    logic [9:0]  x;
    logic [9:0]  y;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic extend;
  } cell_ctl_t;

  // Q16 crossfade, truncated.
  function automatic logic [13:0] blend(input logic [13:0] cur, input logic [13:0] scn,
                                        input logic [16:0] w);
    logic [31:0] acc;
    acc = 32'(cur) * 32'(Q16_ONE - w) + 32'(scn) * 32'(w);
    return acc[29:16];
  endfunction

  // Time plus a delay, saturated to the 48-bit range.
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage

@@ design/tslf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_cell: one scene cell of the ordered scene chain
// Holds one scene; loads a new one, takes its right neighbor on a shift,
// and extends its own release when the extend key matches.
// ----------------------------------------------------------------------------
module tslf_cell import tslf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctl_t   ctl,
  input  entry_t      nxt,
  input  entry_t      fresh,
  input  logic [7:0]  key,
  input  logic [47:0] motion,
  output entry_t      ent,
  output logic        match
);

  logic [47:0] ext_ms;

  assign match  = ent.valid && (ent.id == key);
  assign ext_ms = sat_add48(motion, ent.hold);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.load) begin
      ent <= fresh;
    end else if (ctl.shift) begin
      ent <= nxt;
    end else if (ctl.extend && match && (ent.rel_ms < ext_ms)) begin
      ent.rel_ms <= ext_ms;
    end
  end

endmodule

@@ design/tslf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslf_div: Q16 ratio unit
// Computes floor(num * 65536 / den) for num <= den, one quotient bit per
// cycle into a 17-bit quotient; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module tslf_div import tslf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] q
);

  logic [32:0] rem;
  logic [31:0] dv;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = (cnt == 5'd0) ? rem : {rem[31:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= {1'b0, num};
        dv   <= den;
        cnt  <= '0;
        q    <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          q   <= {q[15:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[15:0], 1'b0};
        end
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

endmodule

@@ design/timed_scene_layer_fader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_scene_layer_fader: desired-state generator for one light
// Keeps an age-ordered chain of timed scenes and a manual override, and on a
// tick uses a live override, else crossfades live scenes over the background.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | in        | in_valid / in_stall     | cmd, now_ms, scene_id, ...
//  out     | out       | out_valid / out_stall   | out_brightness ... table_full
//  cfg     | in        | cfg_write               | cfg_index, cfg_data
//
// One transaction is handled at a time. A tick with a live override goes
// straight to the result; otherwise each of the MAX_SCENES cells passes the
// chain head once (an empty or expired cell is dropped, a scene at full
// weight is blended, and a fading scene is blended after it waits on the
// 17-step ratio unit), followed by a head step that closes the pass, a
// compaction sweep over the cells, and the gain and output states.
// Synchronous reset empties the chain and clears the override and configuration registers.
// A stalled result holds the block in its result state until taken.
//
// The scenes live in a chain of cells, oldest at cell 0. Removal shifts the
// younger cells down by one. A tick rotates the chain through cell 0, where
// each scene is weighted and blended; expired scenes leave an empty cell
// behind, and a compaction sweep closes those gaps afterwards.
module timed_scene_layer_fader import tslf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [47:0] now_ms,
  input  logic [7:0]  scene_id,
  input  logic [31:0] fade_ms,
  input  logic [31:0] hold_ms,
  input  logic [13:0] level,
  input  logic [9:0]  mirek,
  input  logic [9:0]  chroma_x,
  input  logic [9:0]  chroma_y,
  input  logic [47:0] motion_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_brightness,
  output logic [6:0]  out_percent,
  output logic [9:0]  out_mirek,
  output logic [9:0]  out_x,
  output logic [9:0]  out_y,
  output logic        out_on,
  output logic [10:0] transition_ms,
  output logic        scene_present,
  output logic        table_full,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SET_INS, S_T_HEAD, S_T_DIV, S_T_BLEND, S_T_COMPACT, S_T_GAIN, S_RESULT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [13:0] bg_bright;
  logic [9:0]  bg_mirek, bg_x, bg_y;
  logic [8:0]  room_gain;
  logic [6:0]  min_dim;

  // Manual override.
  logic [13:0] man_level;
  logic [9:0]  man_mirek, man_x, man_y;
  logic [47:0] man_until;

  // Captured transaction fields used after the accepting cycle.
  logic [47:0] lt_now;
  entry_t      fresh;

  // Working registers of a tick and the pending result.
  logic [STEP_W-1:0] step;
  logic [13:0] cur_b;
  logic [9:0]  cur_m, cur_x, cur_y;
  logic [16:0] w;
  logic        ramp_out;
  logic [14:0] res_b;
  logic [10:0] res_tr;
  logic        res_tick, res_present, res_full;

  // Chain.
  entry_t    ent   [MAX_SCENES];
  logic      match [MAX_SCENES];
  cell_ctl_t ctl   [MAX_SCENES];
  entry_t    tail_ent;
  logic      all_valid, any_match;
  logic      accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  genvar gk;
  generate
    for (gk = 0; gk < MAX_SCENES; gk++) begin : g_cell
      entry_t nxt_ent;
      if (gk == MAX_SCENES - 1) begin : g_tail
        assign nxt_ent = tail_ent;
      end else begin : g_mid
        assign nxt_ent = ent[gk + 1];
      end
      tslf_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl[gk]),
        .nxt    (nxt_ent),
        .fresh  (fresh),
        .key    (scene_id),
        .motion (motion_ms),
        .ent    (ent[gk]),
        .match  (match[gk])
      );
    end
  endgenerate

  // Evaluation of the chain head during a tick.
  entry_t      head;
  logic        expired, in_ramp, held, kept;
  logic [47:0] d_in, d_out;
  logic [31:0] div_num;
  logic        div_start, div_done;
  logic [16:0] div_q;

  assign head    = ent[0];
  assign expired = ({1'b0, head.rel_ms} + 49'(head.fade)) < {1'b0, lt_now};
  assign kept    = head.valid && !expired;
  assign d_in    = lt_now - head.start_ms;
  assign in_ramp = d_in <= 48'(head.fade);
  assign held    = lt_now < head.rel_ms;
  assign d_out   = lt_now - head.rel_ms;
  assign div_num = in_ramp ? d_in[31:0] :
                   ((d_out > 48'(head.fade)) ? head.fade : d_out[31:0]);
  assign div_start = (state == S_T_HEAD) && (step != STEP_W'(MAX_SCENES)) && kept &&
                     (head.fade != 32'd0) && (in_ramp || !held);

  tslf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (head.fade),
    .done  (div_done),
    .q     (div_q)
  );

  // Cell control: removal and compaction shift every cell from a point on,
  // rotation shifts all of them, and an insert loads the first empty cell.
  always_comb begin
    logic rm_pre, gap_pre, prev_gap;
    rm_pre    = 1'b0;
    gap_pre   = 1'b0;
    prev_gap  = 1'b0;
    all_valid = 1'b1;
    any_match = 1'b0;
    tail_ent  = head;
    if (state != S_T_BLEND) begin
      tail_ent.valid = 1'b0;
    end
    for (int k = 0; k < MAX_SCENES; k++) begin
      all_valid = all_valid & ent[k].valid;
      any_match = any_match | match[k];
    end
    for (int k = 0; k < MAX_SCENES; k++) begin
      rm_pre    = rm_pre | match[k];
      gap_pre   = gap_pre | !ent[k].valid;
      ctl[k]    = '0;
      if (accept && (cmd == CMD_SET || cmd == CMD_REMOVE)) begin
        ctl[k].shift = rm_pre;
      end
      if (accept && cmd == CMD_EXTEND) begin
        ctl[k].extend = 1'b1;
      end
      if (state == S_T_HEAD && step != STEP_W'(MAX_SCENES) && !kept) begin
        ctl[k].shift = 1'b1;
      end
      if (state == S_T_BLEND) begin
        ctl[k].shift = 1'b1;
      end
      if (state == S_T_COMPACT) begin
        ctl[k].shift = gap_pre;
      end
      if (state == S_SET_INS && !all_valid) begin
        ctl[k].load = gap_pre && !prev_gap;
      end
      prev_gap = gap_pre;
    end
  end

  // Result formatting.
  logic [13:0] sat_b;
  logic [26:0] pct_prod;
  logic [6:0]  pct;
  logic [22:0] gain_prod;

  assign sat_b     = (res_b > 15'(BRIGHT_MAX)) ? BRIGHT_MAX : res_b[13:0];
  assign pct_prod  = 27'(sat_b) * 27'(PCT_RECIP);
  assign pct       = pct_prod[25:19];
  assign gain_prod = 23'(cur_b) * 23'(room_gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      bg_bright <= '0;
      bg_mirek  <= '0;
      bg_x      <= '0;
      bg_y      <= '0;
      room_gain <= '0;
      min_dim   <= '0;
      man_level <= '0;
      man_mirek <= '0;
      man_x     <= '0;
      man_y     <= '0;
      man_until <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BG_BRIGHT: bg_bright <= cfg_data;
          REG_BG_MIREK:  bg_mirek  <= cfg_data[9:0];
          REG_BG_X:      bg_x      <= cfg_data[9:0];
          REG_BG_Y:      bg_y      <= cfg_data[9:0];
          REG_GAIN:      room_gain <= cfg_data[8:0];
          REG_MIN_DIM:   min_dim   <= cfg_data[6:0];
          default: ;
        endcase
      end
      // The result state reloads the output itself when the old one leaves.
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lt_now       <= now_ms;
            fresh.valid  <= 1'b1;
            fresh.id     <= scene_id;
            fresh.fade   <= fade_ms;
            fresh.start_ms <= now_ms;
            fresh.rel_ms <= sat_add48(now_ms, hold_ms);
            fresh.hold   <= hold_ms;
            fresh.level  <= level;
            fresh.mirek  <= mirek;
            fresh.x      <= chroma_x;
            fresh.y      <= chroma_y;
            res_tick     <= 1'b0;
            res_present  <= 1'b0;
            res_full     <= 1'b0;
            state        <= S_RESULT;
            unique case (cmd)
              CMD_TICK: begin
                res_tick <= 1'b1;
                if (man_until > now_ms) begin
                  res_b  <= {1'b0, man_level};
                  cur_m  <= man_mirek;
                  cur_x  <= man_x;
                  cur_y  <= man_y;
                  res_tr <= TR_MANUAL;
                end else begin
                  cur_b  <= bg_bright;
                  cur_m  <= bg_mirek;
                  cur_x  <= bg_x;
                  cur_y  <= bg_y;
                  res_tr <= TR_SCENE;
                  step   <= '0;
                  state  <= S_T_HEAD;
                end
              end
              CMD_SET:   state <= S_SET_INS;
              CMD_QUERY: res_present <= any_match;
              CMD_MANUAL: begin
                man_level <= level;
                man_mirek <= mirek;
                man_x     <= chroma_x;
                man_y     <= chroma_y;
                man_until <= sat_add48(now_ms, hold_ms);
              end
              default: ;
            endcase
          end
        end
        S_SET_INS: begin
          res_full <= all_valid;
          state    <= S_RESULT;
        end
        S_T_HEAD: begin
          if (step == STEP_W'(MAX_SCENES)) begin
            step  <= '0;
            state <= S_T_COMPACT;
          end else if (!kept) begin
            step <= step + 1'b1;
          end else if (div_start) begin
            ramp_out <= !in_ramp;
            state    <= S_T_DIV;
          end else begin
            w     <= Q16_ONE;
            state <= S_T_BLEND;
          end
        end
        S_T_DIV: begin
          if (div_done) begin
            w     <= ramp_out ? (Q16_ONE - div_q) : div_q;
            state <= S_T_BLEND;
          end
        end
        S_T_BLEND: begin
          cur_b <= blend(cur_b, head.level, w);
          cur_m <= 10'(blend({4'd0, cur_m}, {4'd0, head.mirek}, w));
          cur_x <= 10'(blend({4'd0, cur_x}, {4'd0, head.x}, w));
          cur_y <= 10'(blend({4'd0, cur_y}, {4'd0, head.y}, w));
          step  <= step + 1'b1;
          state <= S_T_HEAD;
        end
        S_T_COMPACT: begin
          if (step == STEP_W'(MAX_SCENES - 1)) begin
            state <= S_T_GAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_T_GAIN: begin
          res_b <= gain_prod[22:8];
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_brightness <= res_tick ? sat_b : '0;
            out_percent    <= res_tick ? pct : '0;
            out_mirek      <= res_tick ? cur_m : '0;
            out_x          <= res_tick ? cur_x : '0;
            out_y          <= res_tick ? cur_y : '0;
            out_on         <= res_tick && (pct >= min_dim);
            transition_ms  <= res_tick ? res_tr : '0;
            scene_present  <= res_present;
            table_full     <= res_full;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
